[rtl/core/isf_pkg.sv]
// Shared types, codes, constants and fixed-point helpers of the IMU speed fusion block.
// No dependencies; imported by the top level, isf_ctrl, isf_dp and the testbench.
package isf_pkg;

  localparam int PROD_W = 60;
  localparam int MA_W   = 26;
  localparam int MB_W   = 34;

  localparam logic [1:0] OP_IMU = 2'd0;
  localparam logic [1:0] OP_GPS = 2'd1;
  localparam logic [1:0] OP_QRY = 2'd2;

  localparam logic [2:0] CFG_CALIB_THR = 3'd0;
  localparam logic [2:0] CFG_CALIB_DEB = 3'd1;
  localparam logic [2:0] CFG_ALPHA     = 3'd2;
  localparam logic [2:0] CFG_ZUPT_THR  = 3'd3;
  localparam logic [2:0] CFG_ZUPT_HOLD = 3'd4;
  localparam logic [2:0] CFG_EVT_THR   = 3'd5;
  localparam logic [2:0] CFG_EVT_DEB   = 3'd6;

  localparam logic [3:0] MUL_NONE = 4'd0;
  localparam logic [3:0] MUL_D0   = 4'd1;
  localparam logic [3:0] MUL_D1   = 4'd2;
  localparam logic [3:0] MUL_D2   = 4'd3;
  localparam logic [3:0] MUL_FWD  = 4'd4;
  localparam logic [3:0] MUL_AX   = 4'd5;
  localparam logic [3:0] MUL_AY   = 4'd6;
  localparam logic [3:0] MUL_AZ   = 4'd7;
  localparam logic [3:0] MUL_FWDG = 4'd8;
  localparam logic [3:0] MUL_DT   = 4'd9;
  localparam logic [3:0] MUL_DTK  = 4'd10;
  localparam logic [3:0] MUL_ZB   = 4'd11;
  localparam logic [3:0] MUL_E1   = 4'd12;
  localparam logic [3:0] MUL_E2   = 4'd13;

  localparam logic [3:0] WB_NONE    = 4'd0;
  localparam logic [3:0] WB_SEED    = 4'd1;
  localparam logic [3:0] WB_CDEV    = 4'd2;
  localparam logic [3:0] WB_BASE0   = 4'd3;
  localparam logic [3:0] WB_BASE1   = 4'd4;
  localparam logic [3:0] WB_BASE2   = 4'd5;
  localparam logic [3:0] WB_ACC     = 4'd6;
  localparam logic [3:0] WB_SQ      = 4'd7;
  localparam logic [3:0] WB_FWDG    = 4'd8;
  localparam logic [3:0] WB_IMU_END = 4'd9;
  localparam logic [3:0] WB_ZBIAS   = 4'd10;
  localparam logic [3:0] WB_GREST   = 4'd11;
  localparam logic [3:0] WB_ERR     = 4'd12;
  localparam logic [3:0] WB_GSPD    = 4'd13;
  localparam logic [3:0] WB_GBIAS   = 4'd14;
  localparam logic [3:0] WB_QRY     = 4'd15;

  localparam logic [1:0]  AXIS_NONE   = 2'd3;
  localparam logic [15:0] DT_MAX_MS   = 16'd500;
  localparam logic [15:0] GPS_REST_Q6 = 16'd128;
  localparam logic [19:0] SPEED_MAX   = 20'hFFFFF;
  localparam logic [19:0] GRAV_Q16    = 20'd642689;
  localparam logic [15:0] MS2_TO_G    = 16'd26731;
  localparam logic [15:0] ZUPT_RATE   = 16'd1311;
  localparam logic [15:0] GPS_BLEND   = 16'd9830;
  localparam logic [15:0] DT_SCALE    = 16'd60398;
  localparam logic [15:0] GPS_BIAS    = 16'd46603;
  localparam logic signed [16:0] ONE_G_Q12 = 17'sd4096;
  localparam logic [14:0] DEV_MAX     = 15'h7FFF;

  localparam logic signed [PROD_W-1:0] S24_MAX = 60'sd8388607;
  localparam logic signed [PROD_W-1:0] S24_MIN = -60'sd8388608;
  localparam logic signed [PROD_W-1:0] S16_MAX = 60'sd32767;
  localparam logic signed [PROD_W-1:0] S16_MIN = -60'sd32768;
  localparam logic signed [PROD_W-1:0] SPD_MAX_W = 60'sd1048575;

  typedef struct packed {
    logic       load;
    logic [3:0] mul;
    logic [3:0] wb;
    logic       sqrt_start;
    logic       out_load;
  } isf_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       calibrated;
    logic       seeded;
    logic       dt_ok;
    logic       gps_rest;
    logic       sqrt_done;
    logic       lock;
    logic       zero_speed;
    logic       out_free;
  } isf_sts_t;

  // Right shift rounding half away from zero.
  function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
                                                         input int unsigned sh);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] neg;
    half = $signed(PROD_W'(1) << (sh - 1));
    neg  = $signed(PROD_W'(v[PROD_W-1]));
    return (v + half - neg) >>> sh;
  endfunction

  function automatic logic [23:0] clamp_s24(input logic signed [PROD_W-1:0] v);
    if (v > S24_MAX) return S24_MAX[23:0];
    if (v < S24_MIN) return S24_MIN[23:0];
    return v[23:0];
  endfunction

  function automatic logic [15:0] clamp_s16(input logic signed [PROD_W-1:0] v);
    if (v > S16_MAX) return S16_MAX[15:0];
    if (v < S16_MIN) return S16_MIN[15:0];
    return v[15:0];
  endfunction

  function automatic logic [19:0] clamp_speed(input logic signed [PROD_W-1:0] v);
    if (v < 0) return '0;
    if (v > SPD_MAX_W) return SPEED_MAX;
    return v[19:0];
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[rtl/core/isf_if.sv]
// Valid/ready channel interfaces for the input items and the result items.
// Standalone; no package dependency.
interface isf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [15:0]        elapsed_ms;
  logic [15:0]        gps_speed;
  logic [31:0]        now_ms;
  modport source (output valid, op, accel_x, accel_y, accel_z, elapsed_ms, gps_speed, now_ms,
                  input ready);
  modport sink (input valid, op, accel_x, accel_y, accel_z, elapsed_ms, gps_speed, now_ms,
                output ready);
endinterface

interface isf_out_if;
  logic               valid;
  logic               ready;
  logic               calibrated;
  logic [15:0]        fused_speed;
  logic signed [15:0] forward_accel;
  logic               hard_event;
  logic [14:0]        event_deviation;
  modport source (output valid, calibrated, fused_speed, forward_accel, hard_event,
                  event_deviation, input ready);
  modport sink (input valid, calibrated, fused_speed, forward_accel, hard_event,
                event_deviation, output ready);
endinterface

[rtl/core/imu_speed_fusion_zupt.sv]
// Top level of the IMU/GPS speed fusion block with zero-velocity hold and hard-event check.
// Depends on isf_pkg, isf_if, isf_ctrl, isf_dp (which holds isf_isqrt).
//
//  channel | dir | transfer moves
//  --------+-----+-------------------------------------------------------------
//  in_ch   | in  | op, accel_x/y/z, elapsed_ms, gps_speed, now_ms (one item)
//  out_ch  | out | calibrated, fused_speed, forward_accel, hard_event, event_deviation
//  cfg_*   | in  | register write: cfg_we, cfg_index, cfg_data (no read-back)
//
// One item at a time. A rejected sample, a GPS fix before calibration and an unknown op go
// straight to the result. A calibrated IMU sample runs seven shared-multiplier steps (eight
// with the bias trim at zero speed) and an iterative square root; queries and seeds take a
// single write step. Reset (rst_n low, synchronous) restores the register defaults and
// clears all filter state. A result waits in the output register; the next item is taken
// meanwhile and stalls only at its own end if the previous result is still not taken.
module imu_speed_fusion_zupt (
  input  logic         clk,
  input  logic         rst_n,
  isf_in_if.sink       in_ch,
  isf_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import isf_pkg::*;

  isf_cmd_t cmd;
  isf_sts_t sts;
  logic     in_rdy;

  assign in_ch.ready = in_rdy;

  // sequencer: owns the step order
  isf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: state, arithmetic, result register
  isf_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_op               (in_ch.op),
    .in_accel_x          (in_ch.accel_x),
    .in_accel_y          (in_ch.accel_y),
    .in_accel_z          (in_ch.accel_z),
    .in_elapsed_ms       (in_ch.elapsed_ms),
    .in_gps_speed        (in_ch.gps_speed),
    .in_now_ms           (in_ch.now_ms),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_calibrated      (out_ch.calibrated),
    .out_fused_speed     (out_ch.fused_speed),
    .out_forward_accel   (out_ch.forward_accel),
    .out_hard_event      (out_ch.hard_event),
    .out_event_deviation (out_ch.event_deviation)
  );
endmodule

[rtl/core/isf_isqrt.sv]
// Iterative floor square root of a 32-bit value, two radicand bits per cycle.
// Standalone module.
module isf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] radicand,
  output logic        busy,
  output logic [15:0] root
);
  logic [31:0] v_r, r_r, bit_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};
  assign busy  = busy_r;
  assign root  = r_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r) begin
      busy_r <= (bit_r != 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      r_r   <= '0;
      bit_r <= 32'h4000_0000;
    end else if (busy_r) begin
      if ({1'b0, v_r} >= trial) begin
        v_r <= v_r - trial[31:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end
endmodule

[rtl/core/isf_ctrl.sv]
// Sequencer of the speed fusion block: walks each item through datapath steps.
// Depends on isf_pkg for the command and status types and step codes.
module isf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  isf_pkg::isf_sts_t  sts,
  output isf_pkg::isf_cmd_t  cmd
);
  import isf_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_DISP = 5'd1,  S_SEED = 5'd2,  S_CDEV = 5'd3;
  localparam logic [4:0] S_B0   = 5'd4,  S_B1   = 5'd5,  S_B2   = 5'd6,  S_B3   = 5'd7;
  localparam logic [4:0] S_F0   = 5'd8,  S_F1   = 5'd9,  S_F2   = 5'd10, S_F3   = 5'd11;
  localparam logic [4:0] S_F4   = 5'd12, S_F5   = 5'd13, S_F6   = 5'd14, S_F7   = 5'd15;
  localparam logic [4:0] S_F8   = 5'd16, S_F9   = 5'd17, S_GR0  = 5'd18, S_GR1  = 5'd19;
  localparam logic [4:0] S_G0   = 5'd20, S_G1   = 5'd21, S_G2   = 5'd22, S_G3   = 5'd23;
  localparam logic [4:0] S_QRY  = 5'd24, S_DONE = 5'd25;

  logic [4:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.mul        = MUL_NONE;
    cmd.wb         = WB_NONE;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        priority if (sts.op == OP_IMU) begin
          priority if (!sts.dt_ok)      state_nxt = S_DONE;
          else if (sts.calibrated)      state_nxt = S_F0;
          else if (sts.seeded)          state_nxt = S_CDEV;
          else                          state_nxt = S_SEED;
        end else if (sts.op == OP_GPS) begin
          priority if (!sts.calibrated) state_nxt = S_DONE;
          else if (sts.gps_rest)        state_nxt = S_GR0;
          else                          state_nxt = S_G0;
        end else if (sts.op == OP_QRY) begin
          state_nxt = S_QRY;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SEED: begin cmd.wb = WB_SEED; state_nxt = S_DONE; end
      S_CDEV: begin
        cmd.wb    = WB_CDEV;
        state_nxt = sts.lock ? S_DONE : S_B0;
      end
      S_B0: begin cmd.mul = MUL_D0; state_nxt = S_B1; end
      S_B1: begin cmd.wb = WB_BASE0; cmd.mul = MUL_D1; state_nxt = S_B2; end
      S_B2: begin cmd.wb = WB_BASE1; cmd.mul = MUL_D2; state_nxt = S_B3; end
      S_B3: begin cmd.wb = WB_BASE2; state_nxt = S_DONE; end
      S_F0: begin cmd.mul = MUL_FWD; state_nxt = S_F1; end
      S_F1: begin cmd.wb = WB_ACC;  cmd.mul = MUL_AX;   state_nxt = S_F2; end
      S_F2: begin cmd.wb = WB_SQ;   cmd.mul = MUL_FWDG; state_nxt = S_F3; end
      S_F3: begin cmd.wb = WB_FWDG; cmd.mul = MUL_AY;   state_nxt = S_F4; end
      S_F4: begin cmd.wb = WB_SQ;   cmd.mul = MUL_AZ;   state_nxt = S_F5; end
      S_F5: begin cmd.wb = WB_SQ;   cmd.mul = MUL_DT;   state_nxt = S_F6; end
      S_F6: begin cmd.mul = MUL_DTK; cmd.sqrt_start = 1'b1; state_nxt = S_F7; end
      S_F7: begin
        // hold until the root is ready, then close the sample
        if (sts.sqrt_done) begin
          cmd.wb    = WB_IMU_END;
          state_nxt = sts.zero_speed ? S_F8 : S_DONE;
        end
      end
      S_F8:  begin cmd.mul = MUL_ZB; state_nxt = S_F9; end
      S_F9:  begin cmd.wb = WB_ZBIAS; state_nxt = S_DONE; end
      S_GR0: begin cmd.mul = MUL_FWD; state_nxt = S_GR1; end
      S_GR1: begin cmd.wb = WB_GREST; state_nxt = S_DONE; end
      S_G0:  begin cmd.wb = WB_ERR; state_nxt = S_G1; end
      S_G1:  begin cmd.mul = MUL_E1; state_nxt = S_G2; end
      S_G2:  begin cmd.wb = WB_GSPD; cmd.mul = MUL_E2; state_nxt = S_G3; end
      S_G3:  begin cmd.wb = WB_GBIAS; state_nxt = S_DONE; end
      S_QRY: begin cmd.wb = WB_QRY; state_nxt = S_DONE; end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

[rtl/core/isf_dp.sv]
// Datapath of the speed fusion block: filter state, shared multiplier, square root, result register.
// Depends on isf_pkg and instantiates isf_isqrt.
module isf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  isf_pkg::isf_cmd_t  cmd,
  output isf_pkg::isf_sts_t  sts,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         in_op,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic [15:0]        in_elapsed_ms,
  input  logic [15:0]        in_gps_speed,
  input  logic [31:0]        in_now_ms,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_calibrated,
  output logic [15:0]        out_fused_speed,
  output logic signed [15:0] out_forward_accel,
  output logic               out_hard_event,
  output logic [14:0]        out_event_deviation
);
  import isf_pkg::*;

  // configuration
  logic [14:0] calib_thr_r, zupt_thr_r, evt_thr_r;
  logic [15:0] calib_deb_r, alpha_r, zupt_hold_r, evt_deb_r;

  // latched item
  logic [1:0]         op_r;
  logic signed [15:0] acc_in_r [3];
  logic [15:0]        dt_r, gps_r;
  logic [31:0]        now_r;

  // filter state
  logic               cal_r, seeded_r, cand_neg_r, axis_neg_r;
  logic signed [23:0] base_r [3];
  logic [1:0]         cand_axis_r, axis_sel_r;
  logic [31:0]        cand_time_r, still_r, last_evt_r, sq_r;
  logic signed [23:0] bias_r;
  logic [19:0]        speed_r;
  logic [14:0]        magdev_r;
  logic signed [15:0] last_fwd_r;
  logic signed [24:0] acc_r;
  logic signed [21:0] err_r;
  logic               hard_r;
  logic [14:0]        evdev_r;
  logic signed [PROD_W-1:0] prod_r;

  // result register
  logic               out_valid_r, out_cal_r, out_hard_r;
  logic [15:0]        out_speed_r;
  logic signed [15:0] out_fwd_r;
  logic [14:0]        out_dev_r;

  // combinational
  logic signed [PROD_W-1:0] a_w [3];
  logic signed [PROD_W-1:0] d_w [3];
  logic signed [PROD_W-1:0] m_w [3];
  logic signed [PROD_W-1:0] best_mag, raw_w, bias_w, speed_w;
  logic [1:0]               best_idx;
  logic                     best_neg, over, cand_match, lock, still, zero_speed, qry_hit;
  logic [31:0]              cand_time_nxt, still_sum;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [15:0]              root;
  logic                     sqrt_busy;
  logic signed [16:0]       mag_dev_s;
  logic [16:0]              mag_abs;
  logic [25:0]              acc_abs;

  isf_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sq_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_w[i] = PROD_W'(acc_in_r[i]);
      d_w[i] = (a_w[i] <<< 8) - PROD_W'(base_r[i]);
      m_w[i] = d_w[i][PROD_W-1] ? -d_w[i] : d_w[i];
    end
    // first largest deviation wins
    best_mag = '0;
    best_idx = AXIS_NONE;
    best_neg = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (m_w[i] > best_mag) begin
        best_mag = m_w[i];
        best_idx = 2'(i);
        best_neg = d_w[i][PROD_W-1];
      end
    end
  end

  assign over          = best_mag > $signed(PROD_W'({calib_thr_r, 8'b0}));
  assign cand_match    = over && (best_idx == cand_axis_r) && (best_neg == cand_neg_r);
  assign cand_time_nxt = cand_match ? sat_add32(cand_time_r, dt_r) : '0;
  assign lock          = over && (cand_time_nxt >= {16'b0, calib_deb_r});

  always_comb begin
    unique case (axis_sel_r)
      2'd0:    raw_w = a_w[0];
      2'd1:    raw_w = a_w[1];
      default: raw_w = a_w[2];
    endcase
    if (axis_neg_r) raw_w = -raw_w;
  end

  assign bias_w  = PROD_W'(bias_r);
  assign speed_w = $signed(PROD_W'(speed_r));

  assign acc_abs    = acc_r[24] ? 26'(-PROD_W'(acc_r)) : 26'(PROD_W'(acc_r));
  assign still      = acc_abs < 26'(zupt_thr_r);
  assign still_sum  = sat_add32(still_r, dt_r);
  assign zero_speed = still && (still_sum >= {16'b0, zupt_hold_r});

  assign mag_dev_s = $signed({1'b0, root}) - ONE_G_Q12;
  assign mag_abs   = mag_dev_s[16] ? 17'(-mag_dev_s) : 17'(mag_dev_s);

  assign qry_hit = cal_r && (magdev_r >= evt_thr_r) &&
                   ((now_r - last_evt_r) >= {16'b0, evt_deb_r});

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      MUL_D0:   begin mul_a = d_w[0][MA_W-1:0]; mul_b = MB_W'(alpha_r); end
      MUL_D1:   begin mul_a = d_w[1][MA_W-1:0]; mul_b = MB_W'(alpha_r); end
      MUL_D2:   begin mul_a = d_w[2][MA_W-1:0]; mul_b = MB_W'(alpha_r); end
      MUL_FWD:  begin mul_a = raw_w[MA_W-1:0];  mul_b = MB_W'(GRAV_Q16); end
      MUL_AX:   begin mul_a = a_w[0][MA_W-1:0]; mul_b = a_w[0][MB_W-1:0]; end
      MUL_AY:   begin mul_a = a_w[1][MA_W-1:0]; mul_b = a_w[1][MB_W-1:0]; end
      MUL_AZ:   begin mul_a = a_w[2][MA_W-1:0]; mul_b = a_w[2][MB_W-1:0]; end
      MUL_FWDG: begin mul_a = MA_W'(acc_r);     mul_b = MB_W'(MS2_TO_G); end
      MUL_DT:   begin mul_a = MA_W'(dt_r);      mul_b = MB_W'(DT_SCALE); end
      MUL_DTK:  begin mul_a = MA_W'(acc_r);     mul_b = prod_r[MB_W-1:0]; end
      MUL_ZB:   begin mul_a = MA_W'(acc_r);     mul_b = MB_W'(ZUPT_RATE); end
      MUL_E1:   begin mul_a = MA_W'(err_r);     mul_b = MB_W'(GPS_BLEND); end
      MUL_E2:   begin mul_a = MA_W'(err_r);     mul_b = MB_W'(GPS_BIAS); end
      default:  begin mul_a = '0;               mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul != MUL_NONE) prod_r <= mul_p;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_thr_r <= 15'd1229;
      calib_deb_r <= 16'd200;
      alpha_r     <= 16'd1311;
      zupt_thr_r  <= 15'd307;
      zupt_hold_r <= 16'd500;
      evt_thr_r   <= 15'd2048;
      evt_deb_r   <= 16'd2000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CALIB_THR: calib_thr_r <= cfg_data[14:0];
        CFG_CALIB_DEB: calib_deb_r <= cfg_data;
        CFG_ALPHA:     alpha_r     <= cfg_data;
        CFG_ZUPT_THR:  zupt_thr_r  <= cfg_data[14:0];
        CFG_ZUPT_HOLD: zupt_hold_r <= cfg_data;
        CFG_EVT_THR:   evt_thr_r   <= cfg_data[14:0];
        CFG_EVT_DEB:   evt_deb_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      acc_in_r[0] <= in_accel_x;
      acc_in_r[1] <= in_accel_y;
      acc_in_r[2] <= in_accel_z;
      dt_r        <= in_elapsed_ms;
      gps_r       <= in_gps_speed;
      now_r       <= in_now_ms;
    end
  end

  // working registers without reset
  always_ff @(posedge clk) begin
    unique case (cmd.wb)
      WB_ACC:  begin
        acc_r <= 25'(rnd_shift(prod_r, 18) - bias_w);
        sq_r  <= '0;
      end
      WB_SQ:   sq_r  <= sq_r + prod_r[31:0];
      WB_ERR:  err_r <= 22'($signed(PROD_W'({gps_r, 4'b0})) - speed_w);
      default: ;
    endcase
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r       <= 1'b0;
      seeded_r    <= 1'b0;
      base_r[0]   <= '0;
      base_r[1]   <= '0;
      base_r[2]   <= '0;
      cand_axis_r <= AXIS_NONE;
      cand_neg_r  <= 1'b0;
      cand_time_r <= '0;
      axis_sel_r  <= '0;
      axis_neg_r  <= 1'b0;
      bias_r      <= '0;
      speed_r     <= '0;
      still_r     <= '0;
      magdev_r    <= '0;
      last_evt_r  <= '0;
      last_fwd_r  <= '0;
      hard_r      <= 1'b0;
      evdev_r     <= '0;
    end else begin
      if (cmd.load) begin
        hard_r  <= 1'b0;
        evdev_r <= '0;
      end
      unique case (cmd.wb)
        WB_SEED: begin
          base_r[0] <= {acc_in_r[0], 8'b0};
          base_r[1] <= {acc_in_r[1], 8'b0};
          base_r[2] <= {acc_in_r[2], 8'b0};
          seeded_r  <= 1'b1;
        end
        WB_CDEV: begin
          cand_time_r <= cand_time_nxt;
          if (over) begin
            cand_axis_r <= best_idx;
            cand_neg_r  <= best_neg;
          end else begin
            cand_axis_r <= AXIS_NONE;
          end
          if (lock) begin
            axis_sel_r <= best_idx;
            axis_neg_r <= best_neg;
            bias_r     <= '0;
            cal_r      <= 1'b1;
            speed_r    <= '0;
          end
        end
        WB_BASE0: base_r[0] <= clamp_s24(PROD_W'(base_r[0]) + rnd_shift(prod_r, 16));
        WB_BASE1: base_r[1] <= clamp_s24(PROD_W'(base_r[1]) + rnd_shift(prod_r, 16));
        WB_BASE2: base_r[2] <= clamp_s24(PROD_W'(base_r[2]) + rnd_shift(prod_r, 16));
        WB_FWDG:  last_fwd_r <= clamp_s16(rnd_shift(prod_r, 16));
        WB_IMU_END: begin
          magdev_r <= (mag_abs > 17'(DEV_MAX)) ? DEV_MAX : mag_abs[14:0];
          if (still) begin
            still_r <= still_sum;
            if (zero_speed) speed_r <= '0;
          end else begin
            still_r <= '0;
            speed_r <= clamp_speed(speed_w + rnd_shift(prod_r, 24));
          end
        end
        WB_ZBIAS: bias_r <= clamp_s24(bias_w + rnd_shift(prod_r, 16));
        WB_GREST: begin
          bias_r  <= clamp_s24(rnd_shift(prod_r, 18));
          speed_r <= '0;
          still_r <= {16'b0, zupt_hold_r};
        end
        WB_GSPD:  speed_r <= clamp_speed(speed_w + rnd_shift(prod_r, 16));
        WB_GBIAS: bias_r  <= clamp_s24(bias_w + rnd_shift(prod_r, 24));
        WB_QRY: begin
          if (qry_hit) begin
            last_evt_r <= now_r;
            hard_r     <= 1'b1;
            evdev_r    <= magdev_r;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cal_r   <= cal_r;
      out_speed_r <= speed_r[19:4];
      out_fwd_r   <= last_fwd_r;
      out_hard_r  <= hard_r;
      out_dev_r   <= evdev_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_calibrated      = out_cal_r;
  assign out_fused_speed     = out_speed_r;
  assign out_forward_accel   = out_fwd_r;
  assign out_hard_event      = out_hard_r;
  assign out_event_deviation = out_dev_r;

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.calibrated = cal_r;
    sts.seeded     = seeded_r;
    sts.dt_ok      = (dt_r != '0) && (dt_r <= DT_MAX_MS);
    sts.gps_rest   = gps_r < GPS_REST_Q6;
    sts.sqrt_done  = !sqrt_busy;
    sts.lock       = lock;
    sts.zero_speed = zero_speed;
    sts.out_free   = !out_valid_r || out_ready;
  end
endmodule

[sim/tb_top.sv]
// Self-checking testbench for imu_speed_fusion_zupt: directed and random IMU, GPS and query
// items against a cycle-free predictor of the speed fusion filter.
// Depends on isf_pkg, isf_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
  import isf_pkg::*;

  localparam int IDLE_LIMIT  = 5000;  // cycles without any transfer before giving up
  localparam int DRAIN_WAIT  = 40;    // margin after draining; covers the longest item
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic [15:0]        dt;
    logic [15:0]        gps;
    logic [31:0]        now;
  } fusion_item_t;

  typedef struct {
    logic        calibrated;
    logic [15:0] speed;
    logic [15:0] fwd;
    logic        hard;
    logic [14:0] dev;
  } fusion_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  isf_in_if  in_ch();
  isf_out_if out_ch();

  imu_speed_fusion_zupt i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Items waiting to be driven, and results the filter is expected to produce.
  fusion_item_t   pending_items[$];
  fusion_result_t expected_status[$];

  // Shadow of the filter: registers and state, at model precision.
  longint unsigned  reg_val[7];
  bit               cal_locked;
  bit               base_seeded;
  longint           base[3];
  int               cand_axis;
  bit               cand_neg;
  longint unsigned  cand_ms;
  int               fwd_axis;
  bit               fwd_neg;
  longint           bias_q10;
  longint           speed_q10;
  longint unsigned  still_ms;
  longint           mag_dev;
  logic [31:0]      last_event_ms;
  longint           fwd_g_q12;

  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  events_seen;
  bit  gaps_on;
  logic [31:0] query_clock;

  // ---------------------------------------------------------------------------
  // Fixed-point helpers for the predictor
  // ---------------------------------------------------------------------------
  function automatic longint round_shift(longint v, int s);
    longint h;
    h = longint'(1) << (s - 1);
    if (v < 0) return -((-v + h) >>> s);
    return (v + h) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned add_sat32(longint unsigned a, longint unsigned b);
    return (a + b > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : a + b;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint forward_ms2(longint a[3]);
    longint raw;
    raw = a[fwd_axis];
    if (fwd_neg) raw = -raw;
    return round_shift(raw * 642689, 18);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: advance the shadow state by one item and return the status
  // ---------------------------------------------------------------------------
  function automatic void reset_shadow();
    reg_val = '{1229, 200, 1311, 307, 500, 2048, 2000};
    cal_locked = 0;
    base_seeded = 0;
    base = '{0, 0, 0};
    cand_axis = 3;
    cand_neg = 0;
    cand_ms = 0;
    fwd_axis = 0;
    fwd_neg = 0;
    bias_q10 = 0;
    speed_q10 = 0;
    still_ms = 0;
    mag_dev = 0;
    last_event_ms = 0;
    fwd_g_q12 = 0;
  endfunction

  function automatic void apply_sample(longint a[3], longint unsigned dt);
    int     best;
    longint best_dev;
    longint best_mag;
    longint d;
    longint m;
    bit     over;
    bit     neg;
    longint acc;
    longint sq;
    if (dt == 0 || dt > 500) return;
    if (!cal_locked) begin
      if (!base_seeded) begin
        for (int i = 0; i < 3; i++) base[i] = a[i] * 256;
        base_seeded = 1;
        return;
      end
      best = -1;
      best_dev = 0;
      best_mag = 0;
      for (int i = 0; i < 3; i++) begin
        d = a[i] * 256 - base[i];
        m = d < 0 ? -d : d;
        if (m > best_mag) begin
          best_mag = m;
          best_dev = d;
          best = i;
        end
      end
      over = best >= 0 && best_mag > longint'(reg_val[CFG_CALIB_THR]) * 256;
      neg = best_dev < 0;
      if (over && best == cand_axis && neg == cand_neg) begin
        cand_ms = add_sat32(cand_ms, dt);
      end else if (over) begin
        cand_axis = best;
        cand_neg = neg;
        cand_ms = 0;
      end else begin
        cand_axis = 3;
        cand_ms = 0;
      end
      if (over && cand_ms >= reg_val[CFG_CALIB_DEB]) begin
        fwd_axis = best;
        fwd_neg = neg;
        bias_q10 = 0;
        cal_locked = 1;
        speed_q10 = 0;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        d = a[i] * 256 - base[i];
        base[i] = clip(base[i] + round_shift(d * longint'(reg_val[CFG_ALPHA]), 16),
                       -8388608, 8388607);
      end
      return;
    end
    acc = forward_ms2(a) - bias_q10;
    fwd_g_q12 = clip(round_shift(acc * 26731, 16), -32768, 32767);
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    d = floor_sqrt(sq) - 4096;
    if (d < 0) d = -d;
    mag_dev = d > 32767 ? 32767 : d;
    if ((acc < 0 ? -acc : acc) < longint'(reg_val[CFG_ZUPT_THR])) begin
      still_ms = add_sat32(still_ms, dt);
      if (still_ms >= reg_val[CFG_ZUPT_HOLD]) begin
        speed_q10 = 0;
        bias_q10 = clip(bias_q10 + round_shift(acc * 1311, 16), -8388608, 8388607);
      end
    end else begin
      still_ms = 0;
      speed_q10 = clip(speed_q10 + round_shift(acc * longint'(dt) * 60398, 24), 0, 1048575);
    end
  endfunction

  function automatic void apply_gps_fix(longint a[3], longint gps);
    longint err;
    if (!cal_locked) return;
    if (gps < 128) begin
      speed_q10 = 0;
      bias_q10 = clip(forward_ms2(a), -8388608, 8388607);
      still_ms = reg_val[CFG_ZUPT_HOLD];
      return;
    end
    err = gps * 16 - speed_q10;
    speed_q10 = clip(speed_q10 + round_shift(err * 9830, 16), 0, 1048575);
    bias_q10 = clip(bias_q10 + round_shift(err * 46603, 24), -8388608, 8388607);
  endfunction

  function automatic fusion_result_t predict_status(fusion_item_t it);
    fusion_result_t r;
    longint a[3];
    logic [31:0] since;
    a[0] = it.ax;
    a[1] = it.ay;
    a[2] = it.az;
    r.hard = 0;
    r.dev = '0;
    case (it.op)
      OP_IMU: apply_sample(a, it.dt);
      OP_GPS: apply_gps_fix(a, it.gps);
      OP_QRY: begin
        since = it.now - last_event_ms;
        if (cal_locked && mag_dev >= longint'(reg_val[CFG_EVT_THR]) &&
            since >= reg_val[CFG_EVT_DEB]) begin
          last_event_ms = it.now;
          r.hard = 1;
          r.dev = mag_dev[14:0];
        end
      end
      default: ;  // unknown op leaves everything alone
    endcase
    r.calibrated = cal_locked;
    r.speed = 16'(speed_q10 >> 4);
    r.fwd = 16'(fwd_g_q12);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: present pending items, random gap between transfers
  // ---------------------------------------------------------------------------
  fusion_item_t cur_item;
  int in_gap;

  initial begin
    in_ch.valid = 0;
    in_ch.op = '0;
    in_ch.accel_x = '0;
    in_ch.accel_y = '0;
    in_ch.accel_z = '0;
    in_ch.elapsed_ms = '0;
    in_ch.gps_speed = '0;
    in_ch.now_ms = '0;
    out_ch.ready = 0;
    in_gap = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      // Predict at the transfer, so expectations line up with acceptance order.
      if (in_ch.valid && in_ch.ready) begin
        expected_status.push_back(predict_status(cur_item));
        items_sent++;
      end
      // Hold the item while it is offered and not yet taken.
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_ch.op <= cur_item.op;
          in_ch.accel_x <= cur_item.ax;
          in_ch.accel_y <= cur_item.ay;
          in_ch.accel_z <= cur_item.az;
          in_ch.elapsed_ms <= cur_item.dt;
          in_ch.gps_speed <= cur_item.gps;
          in_ch.now_ms <= cur_item.now;
          in_ch.valid <= 1;
          in_gap = gaps_on ? $urandom_range(0, 4) : 0;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: take results with random stalls, compare against the oldest expectation
  // ---------------------------------------------------------------------------
  int out_stall;

  always @(posedge clk) begin
    fusion_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.hard_event) events_seen++;
        if (expected_status.size() == 0) begin
          mismatches++;
          $display("%0t: result without a pending expectation", $time);
        end else begin
          exp_r = expected_status.pop_front();
          if (out_ch.calibrated !== exp_r.calibrated || out_ch.fused_speed !== exp_r.speed ||
              out_ch.forward_accel !== exp_r.fwd || out_ch.hard_event !== exp_r.hard ||
              out_ch.event_deviation !== exp_r.dev) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: mismatch exp %s act %s", $time,
                       $sformatf("cal=%0d spd=%0d fwd=%0d hard=%0d dev=%0d",
                                 exp_r.calibrated, exp_r.speed, $signed(exp_r.fwd),
                                 exp_r.hard, exp_r.dev),
                       $sformatf("cal=%0d spd=%0d fwd=%0d hard=%0d dev=%0d",
                                 out_ch.calibrated, out_ch.fused_speed,
                                 out_ch.forward_accel, out_ch.hard_event,
                                 out_ch.event_deviation));
          end
        end
        out_stall = gaps_on ? $urandom_range(0, 4) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no transfer happens for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d items pending, %0d results outstanding",
               pending_items.size(), expected_status.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic fusion_item_t mk_item(logic [1:0] op, int ax, int ay, int az,
                                           int dt, int gps, logic [31:0] now);
    fusion_item_t it;
    it.op = op;
    it.ax = 16'(ax);
    it.ay = 16'(ay);
    it.az = 16'(az);
    it.dt = 16'(dt);
    it.gps = 16'(gps);
    it.now = now;
    return it;
  endfunction

  // Wait until the block has drained, plus its worst-case item time.
  task automatic wait_drained();
    while (pending_items.size() > 0 || in_ch.valid || expected_status.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    reg_val[idx] = (idx == CFG_CALIB_THR || idx == CFG_ZUPT_THR || idx == CFG_EVT_THR) ?
                   val & 16'h7FFF : val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic int axis_value(int i, int fwd_i);
    // Forward axis either nearly still or moving hard; gravity on one other axis.
    if (i == fwd_i)
      return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 60) - 30
                                         : $urandom_range(0, 8000) - 4000;
    if (i == (fwd_i + 1) % 3) return 4096 + $urandom_range(0, 200) - 100;
    return $urandom_range(0, 200) - 100;
  endfunction

  function automatic fusion_item_t random_item();
    int sel;
    int v[3];
    sel = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) v[i] = axis_value(i, fwd_axis);
    if (sel < 50)
      return mk_item(OP_IMU, v[0], v[1], v[2], $urandom_range(1, 100), $urandom, $urandom);
    if (sel < 60)
      return mk_item(OP_IMU, $urandom, $urandom, $urandom,
                     ($urandom_range(0, 1) != 0) ? $urandom_range(0, 500) : $urandom,
                     $urandom, $urandom);
    if (sel < 75)
      return mk_item(OP_GPS, v[0], v[1], v[2],
                     $urandom, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 200) : $urandom,
                     $urandom);
    if (sel < 92) begin
      query_clock = query_clock + $urandom_range(0, 3000);
      return mk_item(OP_QRY, $urandom, $urandom, $urandom, $urandom, $urandom,
                     ($urandom_range(0, 4) == 0) ? $urandom : query_clock);
    end
    return mk_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    int sign;
    int ax_i;
    int v[3];
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    events_seen = 0;
    query_clock = 0;
    gaps_on = 1;
    reset_shadow();
    rst_n = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Phase 0: strict calibration settings, out-of-band bits set in 15-bit registers.
    write_reg(CFG_CALIB_THR, 16'hFFFF);
    write_reg(CFG_CALIB_DEB, 16'hFFFF);
    write_reg(CFG_ALPHA, 16'hFFFF);
    write_reg(CFG_ZUPT_THR, 16'd307);
    write_reg(CFG_ZUPT_HOLD, 16'd500);
    write_reg(CFG_EVT_THR, 16'd2048);
    write_reg(CFG_EVT_DEB, 16'd2000);

    // Ignored sample times, traffic before calibration, unknown op, then the seed.
    pending_items.push_back(mk_item(OP_IMU, 100, 200, 4096, 0, 0, 0));
    pending_items.push_back(mk_item(OP_IMU, 100, 200, 4096, 501, 0, 0));
    pending_items.push_back(mk_item(OP_IMU, 100, 200, 4096, 16'hFFFF, 0, 0));
    pending_items.push_back(mk_item(OP_GPS, 0, 0, 4096, 10, 16'hFFFF, 0));
    pending_items.push_back(mk_item(OP_GPS, 0, 0, 4096, 10, 0, 0));
    pending_items.push_back(mk_item(OP_QRY, 0, 0, 4096, 10, 0, 32'hFFFF_FFFF));
    pending_items.push_back(mk_item(2'd3, -1, -1, -1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_items.push_back(mk_item(OP_IMU, -32768, -32768, -32768, 1, 0, 0));
    pending_items.push_back(mk_item(OP_IMU, 32767, 32767, 32767, 500, 0, 0));
    pending_items.push_back(mk_item(OP_IMU, -32768, 0, 32767, 500, 0, 0));
    pending_items.push_back(mk_item(OP_IMU, 0, 0, 0, 250, 0, 0));
    for (int n = 0; n < 150; n++) pending_items.push_back(random_item());
    wait_drained();

    // Phase 1: usable calibration settings; hold still, then launch along one axis.
    write_reg(CFG_CALIB_THR, 16'(1229));
    write_reg(CFG_CALIB_DEB, ($urandom_range(0, 1) != 0) ? 16'd0 : 16'($urandom_range(1, 300)));
    write_reg(CFG_ALPHA, 16'($urandom_range(0, 2000)));
    gaps_on = 0;
    ax_i = $urandom_range(0, 2);
    sign = ($urandom_range(0, 1) != 0) ? 1 : -1;
    for (int n = 0; n < 10; n++) begin
      for (int i = 0; i < 3; i++) v[i] = (i == (ax_i + 1) % 3) ? 4096 : $urandom_range(0, 40);
      pending_items.push_back(mk_item(OP_IMU, v[0], v[1], v[2], $urandom_range(5, 20), 0, 0));
    end
    wait_drained();
    gaps_on = 1;
    while (!cal_locked) begin
      for (int n = 0; n < 20; n++) begin
        for (int i = 0; i < 3; i++)
          v[i] = (i == ax_i) ? sign * (6000 + $urandom_range(0, 500)) :
                 (i == (ax_i + 1) % 3) ? 4096 : 0;
        pending_items.push_back(mk_item(OP_IMU, v[0], v[1], v[2], $urandom_range(10, 60), 0, 0));
      end
      wait_drained();
    end

    // Directed calibrated cases: full-scale axes, rest and full-scale fixes, query edges.
    pending_items.push_back(mk_item(OP_IMU, -32768, -32768, -32768, 1, 0, 0));
    pending_items.push_back(mk_item(OP_IMU, 32767, 32767, 32767, 500, 0, 0));
    pending_items.push_back(mk_item(OP_QRY, 0, 0, 0, 0, 0, 32'd0));
    pending_items.push_back(mk_item(OP_QRY, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_items.push_back(mk_item(OP_IMU, 0, 0, 0, 500, 0, 0));
    pending_items.push_back(mk_item(OP_GPS, 0, 0, 4096, 0, 0, 0));
    pending_items.push_back(mk_item(OP_GPS, 0, 0, 4096, 0, 127, 0));
    pending_items.push_back(mk_item(OP_GPS, 0, 0, 4096, 0, 128, 0));
    pending_items.push_back(mk_item(OP_GPS, -32768, -32768, -32768, 0, 16'hFFFF, 0));
    pending_items.push_back(mk_item(OP_GPS, 32767, 0, 0, 0, 16'hFFFF, 0));
    pending_items.push_back(mk_item(2'd3, 0, 0, 0, 0, 0, 0));
    for (int n = 0; n < 100; n++) pending_items.push_back(random_item());
    wait_drained();

    // Phases 2..6: sweep the tracking registers through defaults, extremes and random.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_ZUPT_THR, 16'd0);
          write_reg(CFG_ZUPT_HOLD, 16'd0);
          write_reg(CFG_EVT_THR, 16'd0);
          write_reg(CFG_EVT_DEB, 16'd0);
        end
        1: begin
          write_reg(CFG_ZUPT_THR, 16'h7FFF);
          write_reg(CFG_ZUPT_HOLD, 16'hFFFF);
          write_reg(CFG_EVT_THR, 16'h7FFF);
          write_reg(CFG_EVT_DEB, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_ZUPT_THR, 16'd307);
          write_reg(CFG_ZUPT_HOLD, 16'd500);
          write_reg(CFG_EVT_THR, 16'd2048);
          write_reg(CFG_EVT_DEB, 16'd2000);
        end
        default: begin
          write_reg(CFG_ZUPT_THR, 16'($urandom_range(0, 2000)));
          write_reg(CFG_ZUPT_HOLD, 16'($urandom_range(0, 1000)));
          write_reg(CFG_EVT_THR, 16'($urandom_range(0, 8000)));
          write_reg(CFG_EVT_DEB, 16'($urandom_range(0, 5000)));
        end
      endcase
      write_reg(CFG_CALIB_THR, 16'($urandom));
      gaps_on = (ph != 2);
      for (int n = 0; n < 320; n++) pending_items.push_back(random_item());
      wait_drained();
    end

    $display("covered %0d items, %0d results, %0d hard events, forward axis %0d%s",
             items_sent, results_seen, events_seen, fwd_axis, fwd_neg ? " negated" : "");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
